@@ rtl/ps2_mouse_packet_cursor_tracker_defines.svh @@
// ---------------------------------------------------------------------------
// PS/2 mouse cursor tracker: assertion macros
// Shared property wrappers for the checker file of this block.
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PMPCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PMPCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pmpct_pkg.sv @@
// ---------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Payload types, register indexes, packet phases and header bit positions.
// ---------------------------------------------------------------------------
package pmpct_pkg;

	// Cursor coordinate width
	localparam int COORD_BITS = 12;
	// Screen size register width
	localparam int SIZE_W = 13;

	// Header byte bit positions
	localparam int HDR_LEFT   = 0;
	localparam int HDR_SYNC   = 3;
	localparam int HDR_X_SIGN = 4;
	localparam int HDR_Y_SIGN = 5;
	localparam int HDR_X_OVF  = 6;
	localparam int HDR_Y_OVF  = 7;

	typedef struct packed {
		logic       from_aux;
		logic [7:0] data_byte;
	} pmpct_in_t;

	typedef struct packed {
		logic [11:0] cursor_x;
		logic [11:0] cursor_y;
		logic        left_button;
	} pmpct_out_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_XDELTA = 2'd1,
		PH_YDELTA = 2'd2
	} pmpct_phase_t;

	typedef enum logic {
		CFG_SCREEN_WIDTH  = 1'b0,
		CFG_SCREEN_HEIGHT = 1'b1
	} pmpct_cfg_idx_t;

	localparam logic [SIZE_W-1:0] RST_SCREEN_WIDTH  = SIZE_W'(800);
	localparam logic [SIZE_W-1:0] RST_SCREEN_HEIGHT = SIZE_W'(600);
	localparam logic [COORD_BITS-1:0] RST_POS_X = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RST_POS_Y = COORD_BITS'(300);

endpackage

@@ rtl/ps2_mouse_packet_cursor_tracker.sv @@
// ---------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker
// Assembles 3-byte PS/2 mouse packets from aux-port bytes, moves a clamped
// cursor by the packet deltas and reports position and left button.
// ---------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  item     | item_valid / item_ready  | from_aux, data_byte
//  result   | result_valid/result_ready| cursor_x, cursor_y, left_button
//  config   | cfg_we (no wait)         | cfg_index, cfg_wdata
//
//  One byte per cycle while the result is not stalled: input register, one
//  pass of add and clamp logic, result register. A packet's result is loaded
//  into the result register as its last byte leaves the input register;
//  bytes that finish no packet make no result.
//  A stalled result holds the input register; item_ready then follows
//  result_ready. Reset puts the cursor at (400, 300) and the screen at
//  800 x 600; no clearing pass.
// ---------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker
	import pmpct_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  pmpct_in_t             item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output pmpct_out_t            result,
	input  logic                  cfg_we,
	input  pmpct_cfg_idx_t        cfg_index,
	input  logic [SIZE_W-1:0]     cfg_wdata
);

	localparam int SUM_W = COORD_BITS + 2;
	localparam int CAP_W = COORD_BITS + 1;
	localparam int LIM_W = (SIZE_W > CAP_W) ? SIZE_W : CAP_W;
	localparam int CMP_W = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;

	// Clamp a signed position into [0, lim-1], lim = size limited to [1, 2^COORD_BITS]
	function automatic logic [COORD_BITS-1:0] clamp_coord(
		input logic signed [SUM_W-1:0] v,
		input logic [SIZE_W-1:0]       size
	);
		logic [LIM_W-1:0] cap;
		logic [LIM_W-1:0] lim;
		logic [LIM_W-1:0] lim_m1;
		logic [CMP_W-1:0] v_ext;
		logic [CMP_W-1:0] lim_ext;
		cap = LIM_W'(1) << COORD_BITS;
		if (size == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(size) > cap) begin
			lim = cap;
		end else begin
			lim = LIM_W'(size);
		end
		lim_m1  = lim - LIM_W'(1);
		v_ext   = CMP_W'(v);
		lim_ext = CMP_W'(lim);
		if (v_ext[CMP_W-1]) begin
			clamp_coord = '0;
		end else if (v_ext >= lim_ext) begin
			clamp_coord = lim_m1[COORD_BITS-1:0];
		end else begin
			clamp_coord = v[COORD_BITS-1:0];
		end
	endfunction

	// Configuration
	logic [SIZE_W-1:0] screen_width_q;
	logic [SIZE_W-1:0] screen_height_q;

	// Input register
	logic      item_valid_s1;
	pmpct_in_t item_s1;

	// Packet and cursor state
	pmpct_phase_t          phase_q;
	pmpct_phase_t          phase_nxt;
	logic [7:0]            header_q;
	logic [7:0]            x_delta_q;
	logic [COORD_BITS-1:0] pos_x_q;
	logic [COORD_BITS-1:0] pos_y_q;

	// Result register
	logic       result_valid_q;
	pmpct_out_t result_q;

	// Datapath
	logic                    advance;
	logic                    byte_taken;
	logic                    take_header;
	logic                    take_x_delta;
	logic                    packet_done;
	logic signed [SUM_W-1:0] next_x_raw;
	logic signed [SUM_W-1:0] next_y_raw;
	logic [COORD_BITS-1:0]   next_x;
	logic [COORD_BITS-1:0]   next_y;

	// Move the input register on whenever the result register can take it
	assign advance    = item_valid_s1 && (!result_valid_q || result_ready);
	assign byte_taken = advance && item_s1.from_aux;
	assign item_ready = !item_valid_s1 || advance;

	// Next packet phase
	always_comb begin
		phase_nxt = phase_q;
		if (byte_taken) begin
			unique case (phase_q)
				PH_XDELTA: phase_nxt = PH_YDELTA;
				PH_YDELTA: phase_nxt = PH_HEADER;
				default:   phase_nxt = item_s1.data_byte[HDR_SYNC] ? PH_XDELTA : PH_HEADER;
			endcase
		end
	end

	// Byte capture and packet completion
	always_comb begin
		take_header  = 1'b0;
		take_x_delta = 1'b0;
		packet_done  = 1'b0;
		if (byte_taken) begin
			unique case (phase_q)
				PH_XDELTA: take_x_delta = 1'b1;
				PH_YDELTA: packet_done  = !header_q[HDR_X_OVF] && !header_q[HDR_Y_OVF];
				default:   take_header  = item_s1.data_byte[HDR_SYNC];
			endcase
		end
	end

	// Apply sign-extended deltas: x moves right by dx, y moves down by -dy
	always_comb begin
		next_x_raw = $signed({2'b00, pos_x_q})
			+ SUM_W'($signed({header_q[HDR_X_SIGN], x_delta_q}));
		next_y_raw = $signed({2'b00, pos_y_q})
			- SUM_W'($signed({header_q[HDR_Y_SIGN], item_s1.data_byte}));
		next_x = clamp_coord(next_x_raw, screen_width_q);
		next_y = clamp_coord(next_y_raw, screen_height_q);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
			endcase
		end
	end

	// Input register: load on accept, drop once advanced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Packet and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			header_q  <= '0;
			x_delta_q <= '0;
			pos_x_q   <= RST_POS_X;
			pos_y_q   <= RST_POS_Y;
		end else begin
			phase_q <= phase_nxt;
			if (take_header) begin
				header_q <= item_s1.data_byte;
			end
			if (take_x_delta) begin
				x_delta_q <= item_s1.data_byte;
			end
			if (packet_done) begin
				pos_x_q <= next_x;
				pos_y_q <= next_y;
			end
		end
	end

	// Result register: load on a finished packet, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (packet_done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (packet_done) begin
			result_q.cursor_x    <= next_x;
			result_q.cursor_y    <= next_y;
			result_q.left_button <= header_q[HDR_LEFT];
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ rtl/pmpct_checker.sv @@
// ---------------------------------------------------------------------------
// PS/2 mouse cursor tracker port checker
// Watches the top-level ports for result holding and input flow control.
// ---------------------------------------------------------------------------
`include "ps2_mouse_packet_cursor_tracker_defines.svh"

module pmpct_checker
	import pmpct_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	input logic           item_ready,
	input logic           result_valid,
	input logic           result_ready,
	input pmpct_out_t     result
);

	// Stalled result holds its value
	`PMPCT_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result), "result changed or dropped while stalled")

	// With no result pending the input side is always open
	`PMPCT_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !result_valid, item_ready, "item_ready low with empty result register")

	// A full input register behind a stalled result stays behind it
	`PMPCT_ASSERT_NEXT(a_stall_backpressure, clk, arst_n, result_valid && !result_ready && !item_ready, result_valid && (item_ready == result_ready), "input register not held behind stalled result")

endmodule

bind ps2_mouse_packet_cursor_tracker pmpct_checker u_pmpct_checker (.*);

@@ bench/tb_ps2_mouse_packet_cursor_tracker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// PS/2 mouse packet cursor tracker testbench
// Feeds aux and keyboard bytes through the request channel and keeps its own
// packet tracker that predicts every cursor report. Reports are checked field
// by field in order. Screen sizes change only while the block is quiet.
// ---------------------------------------------------------------------------
module tb_ps2_mouse_packet_cursor_tracker;
	import pmpct_pkg::*;

	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 4;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	pmpct_in_t             item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	pmpct_out_t            result;
	logic                  cfg_we       = 1'b0;
	pmpct_cfg_idx_t        cfg_index    = CFG_SCREEN_WIDTH;
	logic [SIZE_W-1:0]     cfg_wdata    = '0;

	// Bytes waiting to be offered, and cursor reports still owed by the block
	pmpct_in_t  byte_feed_q[$];
	pmpct_out_t cursor_expect_q[$];

	// Tracker copy: screen size and packet assembly state
	logic [SIZE_W-1:0]     scr_w      = RST_SCREEN_WIDTH;
	logic [SIZE_W-1:0]     scr_h      = RST_SCREEN_HEIGHT;
	pmpct_phase_t          pkt_phase  = PH_HEADER;
	logic [7:0]            pkt_header = '0;
	logic [7:0]            pkt_xbyte  = '0;
	logic [COORD_BITS-1:0] cur_x      = RST_POS_X;
	logic [COORD_BITS-1:0] cur_y      = RST_POS_Y;
	logic                  cur_btn    = 1'b0;

	int  mismatches  = 0;
	bit  no_idle     = 1'b0;
	int  rx_hold_req = 0;
	int  hold_seen   = 0;
	int  hold_left   = 0;
	int  take_wait   = 0;
	int  rx_draw;
	int  send_gap    = 0;

	ps2_mouse_packet_cursor_tracker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Clamp a moved coordinate to the screen; size zero acts as one
	function automatic logic [COORD_BITS-1:0] clamp_to_screen(int v, logic [SIZE_W-1:0] size);
		int lim;
		lim = (size == 0) ? 1 : int'(size);
		if (lim > (1 << COORD_BITS))
			lim = 1 << COORD_BITS;
		if (v < 0)
			return '0;
		if (v >= lim)
			return COORD_BITS'(lim - 1);
		return COORD_BITS'(v);
	endfunction

	// Step the packet tracker by one accepted byte; a finished packet owes a report
	task automatic advance_packet(input pmpct_in_t b);
		int dx;
		int dy;
		pmpct_out_t rep;
		if (!b.from_aux)
			return;
		case (pkt_phase)
			PH_XDELTA: begin
				pkt_xbyte = b.data_byte;
				pkt_phase = PH_YDELTA;
			end
			PH_YDELTA: begin
				pkt_phase = PH_HEADER;
				if (!pkt_header[HDR_X_OVF] && !pkt_header[HDR_Y_OVF]) begin
					dx = int'(pkt_xbyte);
					dy = int'(b.data_byte);
					if (pkt_header[HDR_X_SIGN])
						dx -= 256;
					if (pkt_header[HDR_Y_SIGN])
						dy -= 256;
					cur_x   = clamp_to_screen(int'(cur_x) + dx, scr_w);
					cur_y   = clamp_to_screen(int'(cur_y) - dy, scr_h);
					cur_btn = pkt_header[HDR_LEFT];
					rep.cursor_x    = cur_x;
					rep.cursor_y    = cur_y;
					rep.left_button = cur_btn;
					cursor_expect_q.push_back(rep);
				end
			end
			default: begin
				// drop a would-be header without the sync bit
				if (b.data_byte[HDR_SYNC]) begin
					pkt_header = b.data_byte;
					pkt_phase  = PH_XDELTA;
				end else begin
					pkt_phase = PH_HEADER;
				end
			end
		endcase
	endtask

	// Request driver: offer queued bytes, with a drawn gap after each one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			send_gap   <= 0;
		end else if (!item_valid || item_ready) begin
			if (send_gap != 0) begin
				item_valid <= 1'b0;
				send_gap   <= send_gap - 1;
			end else if (byte_feed_q.size() != 0) begin
				item_valid <= 1'b1;
				item       <= byte_feed_q.pop_front();
				send_gap   <= no_idle ? 0 : $urandom_range(0, 7);
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Monitor: predict on accepted requests, check accepted reports, pace ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			take_wait    <= 0;
			hold_left    <= 0;
		end else begin
			if (item_valid && item_ready)
				advance_packet(item);
			if (result_valid && result_ready) begin
				if (cursor_expect_q.size() == 0) begin
					$display("%0t: unexpected report x=%0d y=%0d left=%0b", $time,
						result.cursor_x, result.cursor_y, result.left_button);
					mismatches++;
				end else begin
					if (result.cursor_x !== cursor_expect_q[0].cursor_x) begin
						$display("%0t: cursor_x expected %0d got %0d", $time,
							cursor_expect_q[0].cursor_x, result.cursor_x);
						mismatches++;
					end
					if (result.cursor_y !== cursor_expect_q[0].cursor_y) begin
						$display("%0t: cursor_y expected %0d got %0d", $time,
							cursor_expect_q[0].cursor_y, result.cursor_y);
						mismatches++;
					end
					if (result.left_button !== cursor_expect_q[0].left_button) begin
						$display("%0t: left_button expected %0b got %0b", $time,
							cursor_expect_q[0].left_button, result.left_button);
						mismatches++;
					end
					void'(cursor_expect_q.pop_front());
				end
			end
			// long hold-off on request, else a drawn stall per report
			if (hold_seen != rx_hold_req) begin
				hold_seen    <= rx_hold_req;
				hold_left    <= LONG_HOLD;
				result_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (result_valid && result_ready) begin
				rx_draw = no_idle ? 0 : $urandom_range(0, 7);
				result_ready <= (rx_draw == 0);
				take_wait    <= (rx_draw == 0) ? 0 : rx_draw - 1;
			end else if (take_wait != 0) begin
				take_wait    <= take_wait - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	task automatic push_byte(input logic aux, input logic [7:0] data);
		pmpct_in_t b;
		b.from_aux  = aux;
		b.data_byte = data;
		byte_feed_q.push_back(b);
	endtask

	task automatic push_packet(input logic [7:0] hdr, input logic [7:0] xb, input logic [7:0] yb);
		push_byte(1'b1, hdr);
		push_byte(1'b1, xb);
		push_byte(1'b1, yb);
	endtask

	// Mostly well-formed packets with random content, some strays and keyboard noise
	task automatic push_random(input int n);
		int count;
		int pick;
		logic [7:0] hdr;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				push_byte(1'b0, 8'($urandom));
			end else if (pick == 1) begin
				push_byte(1'b1, 8'($urandom));
				count += 1;
			end else begin
				hdr = 8'($urandom);
				hdr[HDR_SYNC] = 1'b1;
				if ($urandom_range(0, 7) != 0) begin
					hdr[HDR_X_OVF] = 1'b0;
					hdr[HDR_Y_OVF] = 1'b0;
				end
				push_packet(hdr, 8'($urandom), 8'($urandom));
				count += 3;
			end
		end
	endtask

	// Drive the cursor toward the far corner, then back past the near one
	task automatic push_corner_run(input int n);
		for (int i = 0; i < n; i++)
			push_packet(8'h28 | 8'(i & 1), 8'hFF, 8'h00);
		for (int i = 0; i < n; i++)
			push_packet(8'h18 | 8'(i & 1), 8'h00, 8'hFF);
	endtask

	// Hold until every queued byte is taken and every report has come back
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (byte_feed_q.size() != 0 || item_valid || cursor_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_screen(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_wdata <= w;
		scr_w = w;
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_wdata <= h;
		scr_h = h;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: reset position, delta extremes, sync loss, overflow, keyboard byte
		set_screen(SIZE_W'(800), SIZE_W'(600));
		push_packet(8'h09, 8'h00, 8'h00);
		push_packet(8'h28, 8'hFF, 8'h00);
		push_packet(8'h19, 8'h00, 8'hFF);
		push_byte(1'b1, 8'h00);
		push_byte(1'b1, 8'hF7);
		push_packet(8'hC8, 8'h7F, 8'h7F);
		push_packet(8'h48, 8'h01, 8'h01);
		push_packet(8'h88, 8'h80, 8'h80);
		push_byte(1'b1, 8'h3F);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b1, 8'h55);
		push_byte(1'b1, 8'hAA);
		wait_quiet();

		// Stall reports for a long stretch while bytes keep coming back to back
		no_idle <= 1'b1;
		rx_hold_req <= rx_hold_req + 1;
		push_random(60);
		wait_quiet();
		no_idle <= 1'b0;

		set_screen(SIZE_W'(1), SIZE_W'(1));
		@(negedge clk);
		push_random(30);
		wait_quiet();

		set_screen(SIZE_W'(4096), SIZE_W'(4096));
		no_idle <= 1'b1;
		push_corner_run(20);
		wait_quiet();
		no_idle <= 1'b0;
		push_random(25);
		wait_quiet();

		set_screen(SIZE_W'(0), SIZE_W'(0));
		@(negedge clk);
		push_random(20);
		wait_quiet();

		set_screen(SIZE_W'(8191), SIZE_W'(8191));
		@(negedge clk);
		push_corner_run(10);
		push_random(20);
		wait_quiet();

		for (int k = 0; k < 2; k++) begin
			set_screen(SIZE_W'($urandom_range(1, 4096)), SIZE_W'($urandom_range(1, 4096)));
			@(negedge clk);
			push_random(35);
			wait_quiet();
		end

		repeat (8) @(negedge clk);
		if (mismatches == 0 && cursor_expect_q.size() == 0)
			$display("tb_ps2_mouse_packet_cursor_tracker passed");
		else
			$display("tb_ps2_mouse_packet_cursor_tracker failed");
		$finish;
	end

	// Give up long after the slowest correct run would have ended
	initial begin
		#2000000;
		$display("tb_ps2_mouse_packet_cursor_tracker failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/pmpct_pkg.sv
rtl/ps2_mouse_packet_cursor_tracker.sv
rtl/pmpct_checker.sv
bench/tb_ps2_mouse_packet_cursor_tracker.sv
